FILE: rtl/ltf_pkg.sv
// ----------------------------------------------------------------------------
// ltf_pkg: shared types and helpers for the LCL filter step unit
// Field widths, register indexes, contactor codes and saturating arithmetic.
// ----------------------------------------------------------------------------
package ltf_pkg;

	localparam int DATA_W    = 32;
	localparam int CS_W      = 5;
	localparam int IDX_W     = 3;
	localparam int NPH       = 3;
	localparam int PHASES    = 3;
	localparam int FRAC_BITS = 16;

	// Q2.30 smoothing coefficients
	localparam logic [DATA_W-1:0] K_001 = 32'd10737418;
	localparam logic [DATA_W-1:0] K_099 = 32'd1063004406;

	// contactor codes
	localparam logic [CS_W-1:0] CS_OPEN_MAX = 5'd4;
	localparam logic [CS_W-1:0] CS_PRELOAD  = 5'd5;

	// register indexes
	localparam logic [IDX_W-1:0] REG_INV_L1_STEP    = 3'd0;
	localparam logic [IDX_W-1:0] REG_INV_L2_STEP    = 3'd1;
	localparam logic [IDX_W-1:0] REG_GRID_L_OVER    = 3'd2;
	localparam logic [IDX_W-1:0] REG_INV_C_STEP     = 3'd3;
	localparam logic [IDX_W-1:0] REG_CAP_RES        = 3'd4;
	localparam logic [IDX_W-1:0] REG_L1_RES         = 3'd5;
	localparam logic [IDX_W-1:0] REG_L2_RES         = 3'd6;
	localparam logic [IDX_W-1:0] REG_PRELOAD_RES    = 3'd7;

	typedef struct packed {
		logic [DATA_W-1:0] inv_l1_step;
		logic [DATA_W-1:0] inv_l2_step;
		logic [DATA_W-1:0] grid_l_over_step;
		logic [DATA_W-1:0] inv_c_step;
		logic [DATA_W-1:0] cap_resistance;
		logic [DATA_W-1:0] l1_resistance;
		logic [DATA_W-1:0] l2_resistance;
		logic [DATA_W-1:0] preload_resistance;
	} cfg_t;

	// per-word control shared by all lanes
	typedef struct packed {
		logic              lcl;
		logic              open;
		logic              smooth;
		logic [DATA_W-1:0] r2;
	} lane_ctl_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] i1;
		logic signed [DATA_W-1:0] i2;
		logic signed [DATA_W-1:0] mid;
		logic signed [DATA_W-1:0] dac;
	} lane_res_t;

	function automatic logic signed [DATA_W-1:0] sat33(logic signed [DATA_W:0] s);
		logic signed [DATA_W-1:0] r;
		if (s[DATA_W] != s[DATA_W-1])
			r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		else
			r = s[DATA_W-1:0];
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sadd(logic signed [DATA_W-1:0] a,
		logic signed [DATA_W-1:0] b);
		return sat33({a[DATA_W-1], a} + {b[DATA_W-1], b});
	endfunction

	function automatic logic signed [DATA_W-1:0] ssub(logic signed [DATA_W-1:0] a,
		logic signed [DATA_W-1:0] b);
		return sat33({a[DATA_W-1], a} - {b[DATA_W-1], b});
	endfunction

endpackage

FILE: rtl/ltf_in_if.sv
// ----------------------------------------------------------------------------
// ltf_in_if: input word channel
// One filter tick: converter, grid and neutral voltages, contactor, mode.
// ----------------------------------------------------------------------------
interface ltf_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [ltf_pkg::DATA_W-1:0]   conv_volt_a;
	logic signed [ltf_pkg::DATA_W-1:0]   conv_volt_b;
	logic signed [ltf_pkg::DATA_W-1:0]   conv_volt_c;
	logic signed [ltf_pkg::DATA_W-1:0]   grid_volt_a;
	logic signed [ltf_pkg::DATA_W-1:0]   grid_volt_b;
	logic signed [ltf_pkg::DATA_W-1:0]   grid_volt_c;
	logic signed [ltf_pkg::DATA_W-1:0]   neutral_volt;
	logic        [ltf_pkg::CS_W-1:0]     contactor_state;
	logic                                lcl_mode;

	modport source (output valid, conv_volt_a, conv_volt_b, conv_volt_c,
		grid_volt_a, grid_volt_b, grid_volt_c, neutral_volt, contactor_state,
		lcl_mode, input ready);
	modport sink (input valid, conv_volt_a, conv_volt_b, conv_volt_c,
		grid_volt_a, grid_volt_b, grid_volt_c, neutral_volt, contactor_state,
		lcl_mode, output ready);
endinterface

FILE: rtl/ltf_out_if.sv
// ----------------------------------------------------------------------------
// ltf_out_if: result word channel
// Currents, midpoint voltages and grid DAC values for three phases.
// ----------------------------------------------------------------------------
interface ltf_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [ltf_pkg::DATA_W-1:0] l1_current_a;
	logic signed [ltf_pkg::DATA_W-1:0] l1_current_b;
	logic signed [ltf_pkg::DATA_W-1:0] l1_current_c;
	logic signed [ltf_pkg::DATA_W-1:0] l2_current_a;
	logic signed [ltf_pkg::DATA_W-1:0] l2_current_b;
	logic signed [ltf_pkg::DATA_W-1:0] l2_current_c;
	logic signed [ltf_pkg::DATA_W-1:0] mid_volt_a;
	logic signed [ltf_pkg::DATA_W-1:0] mid_volt_b;
	logic signed [ltf_pkg::DATA_W-1:0] mid_volt_c;
	logic signed [ltf_pkg::DATA_W-1:0] grid_dac_a;
	logic signed [ltf_pkg::DATA_W-1:0] grid_dac_b;
	logic signed [ltf_pkg::DATA_W-1:0] grid_dac_c;

	modport source (output valid, l1_current_a, l1_current_b, l1_current_c,
		l2_current_a, l2_current_b, l2_current_c, mid_volt_a, mid_volt_b,
		mid_volt_c, grid_dac_a, grid_dac_b, grid_dac_c, input ready);
	modport sink (input valid, l1_current_a, l1_current_b, l1_current_c,
		l2_current_a, l2_current_b, l2_current_c, mid_volt_a, mid_volt_b,
		mid_volt_c, grid_dac_a, grid_dac_b, grid_dac_c, output ready);
endinterface

FILE: rtl/ltf_cfg_if.sv
// ----------------------------------------------------------------------------
// ltf_cfg_if: configuration write channel
// Register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface ltf_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [ltf_pkg::IDX_W-1:0]  index;
	logic [ltf_pkg::DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ltf_lane.sv
// ----------------------------------------------------------------------------
// ltf_lane: one phase of the filter step
// Sequences the products of one tick through a single registered multiplier.
// ----------------------------------------------------------------------------
module ltf_lane #(
	parameter int FRAC_BITS = ltf_pkg::FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              ack,
	input  ltf_pkg::lane_ctl_t                ctl,
	input  ltf_pkg::cfg_t                     cfg,
	input  logic signed [ltf_pkg::DATA_W-1:0] v1,
	input  logic signed [ltf_pkg::DATA_W-1:0] v2,
	input  logic signed [ltf_pkg::DATA_W-1:0] vn,
	output logic                              done,
	output ltf_pkg::lane_res_t                res
);
	localparam int W  = ltf_pkg::DATA_W;
	localparam int PW = 2 * W;
	localparam int Q30 = 30;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_OPND = 6'b000010,
		S_MUL  = 6'b000100,
		S_WB   = 6'b001000,
		S_CMT  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	typedef enum logic [3:0] {
		OP_A2, OP_GD, OP_A1, OP_D1, OP_DC, OP_D2, OP_CR, OP_SM1, OP_SM2
	} op_t;

	state_t state_q;
	op_t    op_q;

	// filter state
	logic signed [W-1:0] i1_q, i2_q, mem_q, cap_q, vp_q, gd_q, dl_q;
	// per-tick scratch
	logic signed [W-1:0] a2_q, a1_q, d1_q, dc_q, d2_q, cr_q, gdn_q, i2u_q, i2s_q;
	// multiplier path
	logic [W-1:0]  mag_q, coef_q;
	logic          neg_q, sh30_q;
	logic [PW-1:0] prod_q;

	logic signed [W-1:0] opa, diff, v2n, mres, d2m;
	logic [W-1:0]        coef;
	logic                sh30;
	logic [PW-1:0]       rq;

	assign diff = ltf_pkg::ssub(i1_q, i2_q);
	assign v2n  = ltf_pkg::sadd(v2, vn);

	always_comb begin
		opa  = i2_q;
		coef = ctl.r2;
		sh30 = 1'b0;
		unique case (op_q)
			OP_A2: begin
				opa = i2_q; coef = ctl.r2; sh30 = 1'b0;
			end
			OP_GD: begin
				opa = dl_q; coef = cfg.grid_l_over_step; sh30 = 1'b0;
			end
			OP_A1: begin
				opa = i1_q; coef = cfg.l1_resistance; sh30 = 1'b0;
			end
			OP_D1: begin
				opa  = ltf_pkg::ssub(ltf_pkg::ssub(v1, vp_q), a1_q);
				coef = cfg.inv_l1_step; sh30 = 1'b1;
			end
			OP_DC: begin
				opa = diff; coef = cfg.inv_c_step; sh30 = 1'b1;
			end
			OP_D2: begin
				opa  = ctl.lcl ? ltf_pkg::ssub(ltf_pkg::ssub(vp_q, v2n), a2_q)
				               : ltf_pkg::ssub(ltf_pkg::ssub(v1, v2n), a2_q);
				coef = cfg.inv_l2_step; sh30 = 1'b1;
			end
			OP_CR: begin
				opa = diff; coef = cfg.cap_resistance; sh30 = 1'b0;
			end
			OP_SM1: begin
				opa = i2u_q; coef = ltf_pkg::K_001; sh30 = 1'b1;
			end
			OP_SM2: begin
				opa = i2s_q; coef = ltf_pkg::K_099; sh30 = 1'b1;
			end
			default: begin
				opa = i2_q; coef = ctl.r2; sh30 = 1'b0;
			end
		endcase
	end

	// round half away from zero on the magnitude, then saturate
	always_comb begin
		if (sh30_q)
			rq = (prod_q + (PW'(1) << (Q30 - 1))) >> Q30;
		else
			rq = (prod_q + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (neg_q) begin
			if (rq >= (PW'(1) << (W - 1)))
				mres = {1'b1, {(W-1){1'b0}}};
			else
				mres = -$signed(rq[W-1:0]);
		end else begin
			if (rq > PW'({1'b0, {(W-1){1'b1}}}))
				mres = {1'b0, {(W-1){1'b1}}};
			else
				mres = $signed(rq[W-1:0]);
		end
	end

	// L mode with open contactor forces the increment to zero
	assign d2m = (!ctl.lcl && ctl.open) ? '0 : mres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_A2;
			i1_q    <= '0;
			i2_q    <= '0;
			mem_q   <= '0;
			cap_q   <= '0;
			vp_q    <= '0;
			gd_q    <= '0;
			dl_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= OP_A2;
						state_q <= S_OPND;
					end
				end
				S_OPND: state_q <= S_MUL;
				S_MUL:  state_q <= S_WB;
				S_WB: begin
					unique case (op_q)
						OP_A2: begin
							op_q    <= OP_GD;
							state_q <= S_OPND;
						end
						OP_GD: begin
							op_q    <= ctl.lcl ? OP_A1 : OP_D2;
							state_q <= S_OPND;
						end
						OP_A1: begin
							op_q    <= OP_D1;
							state_q <= S_OPND;
						end
						OP_D1: begin
							op_q    <= OP_DC;
							state_q <= S_OPND;
						end
						OP_DC: begin
							op_q    <= OP_D2;
							state_q <= S_OPND;
						end
						OP_D2: begin
							if (ctl.lcl) begin
								op_q    <= OP_CR;
								state_q <= S_OPND;
							end else if (ctl.smooth) begin
								op_q    <= OP_SM1;
								state_q <= S_OPND;
							end else begin
								state_q <= S_CMT;
							end
						end
						OP_CR: begin
							if (ctl.smooth) begin
								op_q    <= OP_SM1;
								state_q <= S_OPND;
							end else begin
								state_q <= S_CMT;
							end
						end
						OP_SM1: begin
							op_q    <= OP_SM2;
							state_q <= S_OPND;
						end
						OP_SM2: begin
							mem_q   <= mres;
							state_q <= S_CMT;
						end
						default: state_q <= S_CMT;
					endcase
				end
				S_CMT: begin
					i1_q  <= ctl.lcl ? ltf_pkg::sadd(i1_q, d1_q) : i2u_q;
					i2_q  <= ctl.smooth ? i2s_q : i2u_q;
					vp_q  <= ctl.lcl ? ltf_pkg::sadd(ltf_pkg::sadd(cr_q, cap_q), vn) : v2;
					if (ctl.lcl)
						cap_q <= ltf_pkg::sadd(cap_q, dc_q);
					gd_q    <= gdn_q;
					dl_q    <= d2_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (ack)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_OPND) begin
			neg_q  <= opa[W-1];
			mag_q  <= opa[W-1] ? (~opa + 1'b1) : opa;
			coef_q <= coef;
			sh30_q <= sh30;
		end
		if (state_q == S_MUL)
			prod_q <= PW'(mag_q) * PW'(coef_q);
		if (state_q == S_WB) begin
			unique case (op_q)
				OP_A2: a2_q  <= mres;
				OP_GD: gdn_q <= mres;
				OP_A1: a1_q  <= mres;
				OP_D1: d1_q  <= mres;
				OP_DC: dc_q  <= mres;
				OP_D2: begin
					d2_q  <= d2m;
					i2u_q <= (!ctl.lcl && ctl.open) ? '0 : ltf_pkg::sadd(i2_q, mres);
				end
				OP_CR:  cr_q  <= mres;
				OP_SM1: i2s_q <= ltf_pkg::sadd(mres, mem_q);
				OP_SM2: ;
				default: ;
			endcase
		end
		if (state_q == S_CMT) begin
			res.i1  <= ctl.lcl ? ltf_pkg::sadd(i1_q, d1_q) : i2u_q;
			res.i2  <= ctl.smooth ? i2s_q : i2u_q;
			res.mid <= ctl.lcl
				? ltf_pkg::ssub(ltf_pkg::sadd(ltf_pkg::sadd(cr_q, cap_q), vn), vn) : v2;
			res.dac <= ltf_pkg::sadd(gd_q, v2);
		end
	end

	assign done = (state_q == S_DONE);

endmodule

FILE: rtl/three_phase_lcl_filter_step_unit.sv
// ----------------------------------------------------------------------------
// three_phase_lcl_filter_step_unit: three-phase LCL filter, one Euler tick/word
// Products per word: N = 3 (L mode, no smoothing) up to 9 (LCL with smoothing).
// One word in flight: the next is accepted only after the lanes hand the last
//   result to the output register; the pace is set by the single registered
//   multiplier each phase lane shares across its products.
// Reset: arst_n clears configuration, all filter state and the channel flags.
// ----------------------------------------------------------------------------
module three_phase_lcl_filter_step_unit #(
	parameter int PHASES    = ltf_pkg::PHASES,
	parameter int FRAC_BITS = ltf_pkg::FRAC_BITS
) (
	input logic        clk,
	input logic        arst_n,
	ltf_in_if.sink     sample,
	ltf_out_if.source  result,
	ltf_cfg_if.sink    cfg
);
	localparam int W   = ltf_pkg::DATA_W;
	localparam int NPH = ltf_pkg::NPH;

	// open contactor resistance, saturated when it does not fit 32 bits
	localparam logic [63:0]  OPEN_RAW = 64'd10000 << FRAC_BITS;
	localparam logic [W-1:0] OPEN_RES = (OPEN_RAW > 64'hFFFF_FFFF)
		? {W{1'b1}} : OPEN_RAW[W-1:0];
	localparam logic [W-1:0] SMOOTH_LIMIT = W'(64'd12 << FRAC_BITS);

	ltf_pkg::cfg_t      cfg_q;
	ltf_pkg::lane_ctl_t ctl_q, ctl_d;
	logic               busy_q, start_q, ovalid_q, ack, all_done;
	logic               accept;

	logic signed [W-1:0] v1_q [NPH];
	logic signed [W-1:0] v2_q [NPH];
	logic signed [W-1:0] vn_q;

	logic [PHASES-1:0]  done_vec;
	ltf_pkg::lane_res_t lres [NPH];

	// merged result word
	logic signed [W-1:0] i1_o [NPH];
	logic signed [W-1:0] i2_o [NPH];
	logic signed [W-1:0] mid_o [NPH];
	logic signed [W-1:0] dac_o [NPH];

	// configuration: always ready, writes land straight in the register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ltf_pkg::REG_INV_L1_STEP: cfg_q.inv_l1_step        <= cfg.data;
				ltf_pkg::REG_INV_L2_STEP: cfg_q.inv_l2_step        <= cfg.data;
				ltf_pkg::REG_GRID_L_OVER: cfg_q.grid_l_over_step   <= cfg.data;
				ltf_pkg::REG_INV_C_STEP:  cfg_q.inv_c_step         <= cfg.data;
				ltf_pkg::REG_CAP_RES:     cfg_q.cap_resistance     <= cfg.data;
				ltf_pkg::REG_L1_RES:      cfg_q.l1_resistance      <= cfg.data;
				ltf_pkg::REG_L2_RES:      cfg_q.l2_resistance      <= cfg.data;
				ltf_pkg::REG_PRELOAD_RES: cfg_q.preload_resistance <= cfg.data;
				default: ;
			endcase
		end
	end

	// contactor decode: open, preload or normal resistance, and smoothing flag
	always_comb begin
		ctl_d.lcl  = sample.lcl_mode;
		ctl_d.open = (sample.contactor_state <= ltf_pkg::CS_OPEN_MAX);
		if (ctl_d.open)
			ctl_d.r2 = OPEN_RES;
		else if (sample.contactor_state == ltf_pkg::CS_PRELOAD)
			ctl_d.r2 = cfg_q.preload_resistance;
		else
			ctl_d.r2 = cfg_q.l2_resistance;
		ctl_d.smooth = (ctl_d.r2 > SMOOTH_LIMIT);
	end

	// one word in flight; the output register frees the lanes early
	assign sample.ready = !busy_q;
	assign accept       = sample.valid && !busy_q;
	assign all_done     = &done_vec;
	assign ack          = all_done && (!ovalid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			start_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept)
				busy_q <= 1'b1;
			else if (ack)
				busy_q <= 1'b0;
			if (ack)
				ovalid_q <= 1'b1;
			else if (result.ready)
				ovalid_q <= 1'b0;
		end
	end

	// captured tick inputs, held for the lanes
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_q   <= ctl_d;
			v1_q[0] <= sample.conv_volt_a;
			v1_q[1] <= sample.conv_volt_b;
			v1_q[2] <= sample.conv_volt_c;
			v2_q[0] <= sample.grid_volt_a;
			v2_q[1] <= sample.grid_volt_b;
			v2_q[2] <= sample.grid_volt_c;
			vn_q    <= sample.neutral_volt;
		end
	end

	// phase lanes; lanes with index PHASES or above stay at zero
	for (genvar p = 0; p < NPH; p++) begin : g_lane
		if (p < PHASES) begin : g_on
			ltf_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.start  (start_q),
				.ack    (ack),
				.ctl    (ctl_q),
				.cfg    (cfg_q),
				.v1     (v1_q[p]),
				.v2     (v2_q[p]),
				.vn     (vn_q),
				.done   (done_vec[p]),
				.res    (lres[p])
			);
		end else begin : g_off
			assign lres[p] = '0;
		end
	end

	// merge stage: lane results into the output word
	always_ff @(posedge clk) begin
		if (ack) begin
			for (int p = 0; p < NPH; p++) begin
				i1_o[p]  <= lres[p].i1;
				i2_o[p]  <= lres[p].i2;
				mid_o[p] <= lres[p].mid;
				dac_o[p] <= lres[p].dac;
			end
		end
	end

	assign result.valid        = ovalid_q;
	assign result.l1_current_a = i1_o[0];
	assign result.l1_current_b = i1_o[1];
	assign result.l1_current_c = i1_o[2];
	assign result.l2_current_a = i2_o[0];
	assign result.l2_current_b = i2_o[1];
	assign result.l2_current_c = i2_o[2];
	assign result.mid_volt_a   = mid_o[0];
	assign result.mid_volt_b   = mid_o[1];
	assign result.mid_volt_c   = mid_o[2];
	assign result.grid_dac_a   = dac_o[0];
	assign result.grid_dac_b   = dac_o[1];
	assign result.grid_dac_c   = dac_o[2];

endmodule

FILE: rtl/ltf_checker.sv
// ----------------------------------------------------------------------------
// ltf_checker: port-level checks for the filter step unit
// Sequencing of input and result words, bound to the top level.
// ----------------------------------------------------------------------------
module ltf_checker (
	input logic clk,
	input logic arst_n,
	input logic s_valid,
	input logic s_ready,
	input logic r_valid,
	input logic r_ready
);
	// a word in flight blocks the next one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("input taken while a word is in flight");

	// a result never appears the cycle after a word is taken
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !$rose(r_valid))
		else $error("result too early");

	// a new result frees the input side
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> s_ready)
		else $error("input not ready after result");

	// stalled result stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result dropped while stalled");
endmodule

bind three_phase_lcl_filter_step_unit ltf_checker u_ltf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample.valid),
	.s_ready (sample.ready),
	.r_valid (result.valid),
	.r_ready (result.ready)
);
